// ===== hdl/event_queue_subscriber_router_unit_defines.svh =====
// assertion macros for the event queue subscriber router
`ifndef EVENT_QUEUE_SUBSCRIBER_ROUTER_UNIT_DEFINES_SVH
`define EVENT_QUEUE_SUBSCRIBER_ROUTER_UNIT_DEFINES_SVH

// same-cycle implication
`define EQSR_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define EQSR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/eqsr_pkg.sv =====
// types and constants shared by the event queue subscriber router
`timescale 1ns / 1ps
`default_nettype none
package eqsr_pkg;

	localparam int unsigned SLOT_W    = 8;
	localparam int unsigned ID_W      = 8;
	localparam int unsigned PAYLOAD_W = 32;
	localparam int unsigned ENTRY_W   = ID_W + PAYLOAD_W;

	localparam logic [2:0] OP_SUBSCRIBE   = 3'd0;
	localparam logic [2:0] OP_UNSUBSCRIBE = 3'd1;
	localparam logic [2:0] OP_POST        = 3'd2;
	localparam logic [2:0] OP_DISPATCH    = 3'd3;
	localparam logic [2:0] OP_FLUSH       = 3'd4;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_ARG     = 3'd1;
	localparam logic [2:0] ST_TABLE_FULL  = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
	localparam logic [2:0] ST_QUEUE_FULL  = 3'd4;
	localparam logic [2:0] ST_QUEUE_EMPTY = 3'd5;
	localparam logic [2:0] ST_DROPPED     = 3'd6;

	typedef struct packed {
		logic [2:0]           operation;
		logic [ID_W-1:0]      event_id;
		logic [SLOT_W-1:0]    handler_id;
		logic [PAYLOAD_W-1:0] payload;
	} eqsr_req_t;

	typedef struct packed {
		logic [2:0]           status;
		logic                 call_valid;
		logic [SLOT_W-1:0]    call_handler;
		logic [ID_W-1:0]      call_event;
		logic [PAYLOAD_W-1:0] call_payload;
		logic [3:0]           pending_count;
		logic                 last;
	} eqsr_res_t;

	typedef struct packed {
		logic [SLOT_W-1:0] value;
		logic              match;
		logic              empty;
		logic              more;
	} eqsr_slot_stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_EV_WAIT,
		S_ROW_WAIT,
		S_SCAN,
		S_FIN
	} eqsr_state_t;

endpackage
`default_nettype wire

// ===== hdl/eqsr_sub_mem.sv =====
// subscriber row memory with per-row valid bits cleared at reset
`timescale 1ns / 1ps
`default_nettype none
module eqsr_sub_mem #(
	parameter int unsigned ROWS  = 32,
	parameter int unsigned ROW_W = 32,
	parameter int unsigned AW    = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [ROW_W-1:0] rd_row,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [ROW_W-1:0] wr_row
);

	logic [ROW_W-1:0] mem [ROWS];
	logic [ROW_W-1:0] rdata_q;
	logic [ROWS-1:0]  vld_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	// rows never written read as all slots empty
	assign rd_row = rvld_q ? rdata_q : '0;

endmodule
`default_nettype wire

// ===== hdl/eqsr_ring_mem.sv =====
// event ring storage, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module eqsr_ring_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned IW    = 4
) (
	input  wire logic                         clk,
	input  wire logic                         rd_en,
	input  wire logic [IW-1:0]                rd_addr,
	output logic      [eqsr_pkg::ENTRY_W-1:0] rd_data,
	input  wire logic                         wr_en,
	input  wire logic [IW-1:0]                wr_addr,
	input  wire logic [eqsr_pkg::ENTRY_W-1:0] wr_data
);

	logic [eqsr_pkg::ENTRY_W-1:0] mem [DEPTH];
	logic [eqsr_pkg::ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign rd_data = rdata_q;

endmodule
`default_nettype wire

// ===== hdl/eqsr_slot_unit.sv =====
// shared slot compare unit: picks one slot of a row and tests it
`timescale 1ns / 1ps
`default_nettype none
module eqsr_slot_unit #(
	parameter int unsigned SLOTS = 4,
	parameter int unsigned SW    = 2
) (
	input  wire logic [SLOTS*eqsr_pkg::SLOT_W-1:0] row,
	input  wire logic [SW-1:0]                     idx,
	input  wire logic [eqsr_pkg::SLOT_W-1:0]       handler,
	output eqsr_pkg::eqsr_slot_stat_t              stat
);

	logic [SLOTS-1:0] occ;
	logic [SLOTS-1:0] occ_hi;

	always_comb begin
		for (int s = 0; s < SLOTS; s++) begin
			occ[s] = row[s*eqsr_pkg::SLOT_W +: eqsr_pkg::SLOT_W] != '0;
		end
	end

	// occupied slots above the current one
	assign occ_hi = (occ >> idx) >> 1;

	always_comb begin
		stat.value = row[idx*eqsr_pkg::SLOT_W +: eqsr_pkg::SLOT_W];
		stat.match = stat.value == handler;
		stat.empty = stat.value == '0;
		stat.more  = occ_hi != '0;
	end

endmodule
`default_nettype wire

// ===== hdl/event_queue_subscriber_router_unit.sv =====
// top level of the event queue subscriber router: sequencer and queue pointers
//
// channel   | handshake           | payload
// ----------+---------------------+-----------------------------
// request   | start, busy         | req (operation, ids, payload)
// result    | res_strobe          | res (status, call, count, last)
//
// post, flush and bad requests: exec then fin states, result in the cycle after fin
// subscribe and unsubscribe: row read, then one slot compared per cycle, then fin
// dispatch: ring read, row read, then one slot per cycle
// dispatch strobes a call in the cycle after each occupied slot's scan, back to back if adjacent
// reset clears pointers and per-row valid bits, so the table reads empty at once
// the receiver takes every strobed result; nothing waits on it
`timescale 1ns / 1ps
`default_nettype none
`include "event_queue_subscriber_router_unit_defines.svh"
module event_queue_subscriber_router_unit #(
	parameter int unsigned QUEUE_DEPTH     = 16,
	parameter int unsigned EVENT_COUNT     = 32,
	parameter int unsigned SLOTS_PER_EVENT = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire eqsr_pkg::eqsr_req_t req,
	output logic                     res_strobe,
	output eqsr_pkg::eqsr_res_t      res
);

	localparam int unsigned IW    = $clog2(QUEUE_DEPTH);
	localparam int unsigned PW    = IW + 1;
	localparam int unsigned EW    = (EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1;
	localparam int unsigned SW    = (SLOTS_PER_EVENT > 1) ? $clog2(SLOTS_PER_EVENT) : 1;
	localparam int unsigned ROW_W = SLOTS_PER_EVENT * eqsr_pkg::SLOT_W;

	eqsr_pkg::eqsr_state_t state_q, state_nxt;
	eqsr_pkg::eqsr_req_t   req_q;
	eqsr_pkg::eqsr_res_t   res_q, res_nxt;
	eqsr_pkg::eqsr_slot_stat_t stat;

	logic [PW-1:0]    wp_q, rp_q, queued;
	logic [SW-1:0]    slot_q, found_idx_q, empt_idx_q;
	logic             found_q, empt_q, emitted_q, tbl_q, res_strobe_q;
	logic [2:0]       status_q, fin_status;
	logic [eqsr_pkg::ID_W-1:0]      eid_q;
	logic [eqsr_pkg::PAYLOAD_W-1:0] epl_q;
	logic [ROW_W-1:0] row_q, row_rdata, row_wr;
	logic [eqsr_pkg::ENTRY_W-1:0] ring_rdata;

	logic acc, tbl_op, is_disp, args_ok, eid_ok, q_full, q_empty, slot_last;
	logic row_rd_en, row_wr_en, ring_rd_en, ring_wr_en, emit_call, emit_fin;
	logic [EW-1:0] row_rd_addr;

	assign busy    = state_q != eqsr_pkg::S_IDLE;
	assign acc     = start && !busy;
	assign queued  = wp_q - rp_q;
	assign q_full  = queued >= PW'(QUEUE_DEPTH - 1);
	assign q_empty = queued == '0;
	assign tbl_op  = req_q.operation inside {eqsr_pkg::OP_SUBSCRIBE, eqsr_pkg::OP_UNSUBSCRIBE};
	assign is_disp = req_q.operation == eqsr_pkg::OP_DISPATCH;
	assign args_ok = ({1'b0, req_q.event_id} < 9'(EVENT_COUNT)) && (req_q.handler_id != '0);
	assign eid_ok  = {1'b0, ring_rdata[eqsr_pkg::ENTRY_W-1 -: eqsr_pkg::ID_W]}
		< 9'(EVENT_COUNT);
	assign slot_last = slot_q == SW'(SLOTS_PER_EVENT - 1);

	eqsr_sub_mem #(
		.ROWS  (EVENT_COUNT),
		.ROW_W (ROW_W),
		.AW    (EW)
	) u_sub_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (row_rd_en),
		.rd_addr (row_rd_addr),
		.rd_row  (row_rdata),
		.wr_en   (row_wr_en),
		.wr_addr (req_q.event_id[EW-1:0]),
		.wr_row  (row_wr)
	);

	eqsr_ring_mem #(
		.DEPTH (QUEUE_DEPTH),
		.IW    (IW)
	) u_ring_mem (
		.clk     (clk),
		.rd_en   (ring_rd_en),
		.rd_addr (rp_q[IW-1:0]),
		.rd_data (ring_rdata),
		.wr_en   (ring_wr_en),
		.wr_addr (wp_q[IW-1:0]),
		.wr_data ({req_q.event_id, req_q.payload})
	);

	eqsr_slot_unit #(
		.SLOTS (SLOTS_PER_EVENT),
		.SW    (SW)
	) u_slot_unit (
		.row     (row_q),
		.idx     (slot_q),
		.handler (req_q.handler_id),
		.stat    (stat)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			eqsr_pkg::S_IDLE: begin
				if (acc) begin
					state_nxt = eqsr_pkg::S_EXEC;
				end
			end
			eqsr_pkg::S_EXEC: begin
				if (tbl_op) begin
					state_nxt = args_ok ? eqsr_pkg::S_ROW_WAIT : eqsr_pkg::S_FIN;
				end else if (is_disp) begin
					state_nxt = q_empty ? eqsr_pkg::S_FIN : eqsr_pkg::S_EV_WAIT;
				end else begin
					state_nxt = eqsr_pkg::S_FIN;
				end
			end
			eqsr_pkg::S_EV_WAIT: begin
				state_nxt = eid_ok ? eqsr_pkg::S_ROW_WAIT : eqsr_pkg::S_FIN;
			end
			eqsr_pkg::S_ROW_WAIT: begin
				state_nxt = eqsr_pkg::S_SCAN;
			end
			eqsr_pkg::S_SCAN: begin
				if (is_disp && !stat.empty && !stat.more) begin
					state_nxt = eqsr_pkg::S_IDLE;
				end else if (slot_last) begin
					state_nxt = eqsr_pkg::S_FIN;
				end
			end
			eqsr_pkg::S_FIN: begin
				state_nxt = eqsr_pkg::S_IDLE;
			end
			default: begin
				state_nxt = eqsr_pkg::S_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		row_rd_en   = 1'b0;
		row_rd_addr = req_q.event_id[EW-1:0];
		ring_rd_en  = 1'b0;
		ring_wr_en  = 1'b0;
		emit_call   = 1'b0;
		emit_fin    = 1'b0;
		row_wr_en   = 1'b0;
		case (state_q)
			eqsr_pkg::S_EXEC: begin
				row_rd_en  = tbl_op && args_ok;
				ring_wr_en = (req_q.operation == eqsr_pkg::OP_POST) && !q_full;
				ring_rd_en = is_disp && !q_empty;
			end
			eqsr_pkg::S_EV_WAIT: begin
				row_rd_en   = eid_ok;
				row_rd_addr = ring_rdata[eqsr_pkg::PAYLOAD_W +: EW];
			end
			eqsr_pkg::S_SCAN: begin
				emit_call = is_disp && !stat.empty;
			end
			eqsr_pkg::S_FIN: begin
				emit_fin = 1'b1;
				if (tbl_q) begin
					if (req_q.operation == eqsr_pkg::OP_UNSUBSCRIBE) begin
						row_wr_en = found_q;
					end else begin
						row_wr_en = !found_q && empt_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		fin_status = status_q;
		if (tbl_q) begin
			if (req_q.operation == eqsr_pkg::OP_UNSUBSCRIBE) begin
				fin_status = found_q ? eqsr_pkg::ST_OK : eqsr_pkg::ST_NOT_FOUND;
			end else begin
				fin_status = (found_q || empt_q) ? eqsr_pkg::ST_OK : eqsr_pkg::ST_TABLE_FULL;
			end
		end
	end

	always_comb begin
		row_wr = row_q;
		if (req_q.operation == eqsr_pkg::OP_UNSUBSCRIBE) begin
			row_wr[found_idx_q*eqsr_pkg::SLOT_W +: eqsr_pkg::SLOT_W] = '0;
		end else begin
			row_wr[empt_idx_q*eqsr_pkg::SLOT_W +: eqsr_pkg::SLOT_W] = req_q.handler_id;
		end
	end

	always_comb begin
		res_nxt.status        = fin_status;
		res_nxt.call_valid    = 1'b0;
		res_nxt.call_handler  = '0;
		res_nxt.call_event    = '0;
		res_nxt.call_payload  = '0;
		res_nxt.pending_count = 4'(queued);
		res_nxt.last          = 1'b1;
		if (emit_call) begin
			res_nxt.status       = eqsr_pkg::ST_OK;
			res_nxt.call_valid   = 1'b1;
			res_nxt.call_handler = stat.value;
			res_nxt.call_event   = eid_q;
			res_nxt.call_payload = epl_q;
			res_nxt.last         = !stat.more;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= eqsr_pkg::S_IDLE;
			wp_q         <= '0;
			rp_q         <= '0;
			slot_q       <= '0;
			found_q      <= 1'b0;
			empt_q       <= 1'b0;
			emitted_q    <= 1'b0;
			tbl_q        <= 1'b0;
			res_strobe_q <= 1'b0;
		end else begin
			state_q      <= state_nxt;
			res_strobe_q <= emit_call || emit_fin;
			if (ring_wr_en) begin
				wp_q <= wp_q + 1'b1;
			end
			if (ring_rd_en) begin
				rp_q <= rp_q + 1'b1;
			end
			if (state_q == eqsr_pkg::S_EXEC) begin
				tbl_q     <= tbl_op && args_ok;
				found_q   <= 1'b0;
				empt_q    <= 1'b0;
				emitted_q <= 1'b0;
				slot_q    <= '0;
				if (req_q.operation == eqsr_pkg::OP_FLUSH) begin
					rp_q <= wp_q;
				end
			end
			if (state_q == eqsr_pkg::S_SCAN) begin
				slot_q <= slot_q + 1'b1;
				if (!found_q && stat.match) begin
					found_q <= 1'b1;
				end
				if (!empt_q && stat.empty) begin
					empt_q <= 1'b1;
				end
				if (emit_call) begin
					emitted_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_q <= req;
		end
		if (state_q == eqsr_pkg::S_EXEC) begin
			if (tbl_op) begin
				status_q <= args_ok ? eqsr_pkg::ST_OK : eqsr_pkg::ST_BAD_ARG;
			end else begin
				case (req_q.operation)
					eqsr_pkg::OP_POST:     status_q <= q_full ? eqsr_pkg::ST_QUEUE_FULL
						: eqsr_pkg::ST_OK;
					eqsr_pkg::OP_DISPATCH: status_q <= q_empty ? eqsr_pkg::ST_QUEUE_EMPTY
						: eqsr_pkg::ST_OK;
					eqsr_pkg::OP_FLUSH:    status_q <= eqsr_pkg::ST_OK;
					default:               status_q <= eqsr_pkg::ST_BAD_ARG;
				endcase
			end
		end
		if (state_q == eqsr_pkg::S_EV_WAIT) begin
			eid_q <= ring_rdata[eqsr_pkg::ENTRY_W-1 -: eqsr_pkg::ID_W];
			epl_q <= ring_rdata[eqsr_pkg::PAYLOAD_W-1:0];
			if (!eid_ok) begin
				status_q <= eqsr_pkg::ST_DROPPED;
			end
		end
		if (state_q == eqsr_pkg::S_ROW_WAIT) begin
			row_q <= row_rdata;
		end
		if (state_q == eqsr_pkg::S_SCAN) begin
			if (!found_q && stat.match) begin
				found_idx_q <= slot_q;
			end
			if (!empt_q && stat.empty) begin
				empt_idx_q <= slot_q;
			end
		end
		if (emit_call || emit_fin) begin
			res_q <= res_nxt;
		end
	end

	assign res_strobe = res_strobe_q;
	assign res        = res_q;

	`EQSR_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted request did not raise busy")
	`EQSR_ASSERT_IMPL(a_queue_bound, clk, arst_n, 1'b1, queued <= PW'(QUEUE_DEPTH - 1), "queue over capacity")
	`EQSR_ASSERT_IMPL(a_nocall_last, clk, arst_n, res_strobe_q && !res_q.call_valid, res_q.last, "non-call result not last")
	`EQSR_ASSERT_IMPL(a_last_idle, clk, arst_n, res_strobe_q && res_q.last, !busy, "busy after final result")
	`EQSR_ASSERT_IMPL(a_more_busy, clk, arst_n, res_strobe_q && !res_q.last, busy && emitted_q, "idle with results pending")

endmodule
`default_nettype wire

// ===== verif/eqsr_router_checker.sv =====
// checker for the event queue subscriber router: predicts each request's results and compares
`timescale 1ns / 1ps
module eqsr_router_checker #(
	parameter int unsigned QUEUE_DEPTH     = 16,
	parameter int unsigned EVENT_COUNT     = 32,
	parameter int unsigned SLOTS_PER_EVENT = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                busy,
	input  wire eqsr_pkg::eqsr_req_t req,
	input  wire logic                res_strobe,
	input  wire eqsr_pkg::eqsr_res_t res,
	output int                       fail_count,
	output int                       outstanding
);
	import eqsr_pkg::*;

	localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);

	logic [SLOT_W-1:0]  handlers [EVENT_COUNT][SLOTS_PER_EVENT];
	logic [ENTRY_W-1:0] ring [QUEUE_DEPTH];
	logic [IDX_W:0]     wr_ptr;
	logic [IDX_W:0]     rd_ptr;
	eqsr_res_t          outcome_q [$];
	int                 error_tally;

	function automatic logic [IDX_W:0] queue_fill();
		return wr_ptr - rd_ptr;
	endfunction

	function automatic eqsr_res_t outcome(input logic [2:0] st, input logic valid,
		input logic [SLOT_W-1:0] hd, input logic [ID_W-1:0] ev,
		input logic [PAYLOAD_W-1:0] pl, input logic is_last);
		eqsr_res_t o;
		o.status        = st;
		o.call_valid    = valid;
		o.call_handler  = hd;
		o.call_event    = ev;
		o.call_payload  = pl;
		o.pending_count = 4'(queue_fill());
		o.last          = is_last;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		error_tally++;
		if (error_tally <= 40)
			$display("mismatch %s at %0t: got %0h expected %0h", what, $realtime, got, want);
	endtask

	task automatic apply_request(input eqsr_req_t r);
		logic [2:0]         st;
		int                 slot;
		int                 total;
		int                 k;
		logic [ENTRY_W-1:0] entry;
		logic [ID_W-1:0]    eid;
		logic [PAYLOAD_W-1:0] epl;
		st = ST_OK;
		case (r.operation)
			OP_SUBSCRIBE, OP_UNSUBSCRIBE: begin
				if (r.event_id >= EVENT_COUNT || r.handler_id == '0) begin
					st = ST_BAD_ARG;
				end else begin
					slot = -1;
					for (int i = 0; i < SLOTS_PER_EVENT; i++)
						if (slot < 0 && handlers[r.event_id][i] == r.handler_id)
							slot = i;
					if (r.operation == OP_UNSUBSCRIBE) begin
						if (slot >= 0)
							handlers[r.event_id][slot] = '0;
						else
							st = ST_NOT_FOUND;
					end else if (slot < 0) begin
						st = ST_TABLE_FULL;
						for (int i = 0; i < SLOTS_PER_EVENT; i++)
							if (st == ST_TABLE_FULL && handlers[r.event_id][i] == '0) begin
								handlers[r.event_id][i] = r.handler_id;
								st = ST_OK;
							end
					end
				end
			end
			OP_POST: begin
				if (queue_fill() >= QUEUE_DEPTH - 1) begin
					st = ST_QUEUE_FULL;
				end else begin
					ring[wr_ptr[IDX_W-1:0]] = {r.event_id, r.payload};
					wr_ptr = wr_ptr + 1'b1;
				end
			end
			OP_DISPATCH: begin
				if (queue_fill() == '0) begin
					st = ST_QUEUE_EMPTY;
				end else begin
					entry  = ring[rd_ptr[IDX_W-1:0]];
					rd_ptr = rd_ptr + 1'b1;
					eid    = entry[ENTRY_W-1:PAYLOAD_W];
					epl    = entry[PAYLOAD_W-1:0];
					if (eid >= EVENT_COUNT) begin
						st = ST_DROPPED;
					end else begin
						total = 0;
						for (int i = 0; i < SLOTS_PER_EVENT; i++)
							if (handlers[eid][i] != '0)
								total++;
						if (total > 0) begin
							k = 0;
							for (int i = 0; i < SLOTS_PER_EVENT; i++)
								if (handlers[eid][i] != '0) begin
									k++;
									outcome_q.push_back(outcome(ST_OK, 1'b1,
										handlers[eid][i], eid, epl, k == total));
								end
							return;
						end
					end
				end
			end
			OP_FLUSH: begin
				rd_ptr = wr_ptr;
			end
			default: begin
				st = ST_BAD_ARG;
			end
		endcase
		outcome_q.push_back(outcome(st, 1'b0, '0, '0, '0, 1'b1));
	endtask

	always @(posedge clk or negedge arst_n) begin
		eqsr_res_t want;
		if (!arst_n) begin
			for (int e = 0; e < EVENT_COUNT; e++)
				for (int s = 0; s < SLOTS_PER_EVENT; s++)
					handlers[e][s] = '0;
			for (int q = 0; q < QUEUE_DEPTH; q++)
				ring[q] = '0;
			wr_ptr = '0;
			rd_ptr = '0;
			outcome_q.delete();
			error_tally = 0;
			outstanding <= 0;
			fail_count  <= 0;
		end else begin
			if (start && !busy)
				apply_request(req);
			if (res_strobe) begin
				if (outcome_q.size() == 0) begin
					report_mismatch("unexpected result", 64'(res), '0);
				end else begin
					want = outcome_q.pop_front();
					if (res.status !== want.status)
						report_mismatch("status", 64'(res.status), 64'(want.status));
					if (res.call_valid !== want.call_valid)
						report_mismatch("call_valid", 64'(res.call_valid), 64'(want.call_valid));
					if (res.call_handler !== want.call_handler)
						report_mismatch("call_handler", 64'(res.call_handler),
							64'(want.call_handler));
					if (res.call_event !== want.call_event)
						report_mismatch("call_event", 64'(res.call_event), 64'(want.call_event));
					if (res.call_payload !== want.call_payload)
						report_mismatch("call_payload", 64'(res.call_payload),
							64'(want.call_payload));
					if (res.pending_count !== want.pending_count)
						report_mismatch("pending_count", 64'(res.pending_count),
							64'(want.pending_count));
					if (res.last !== want.last)
						report_mismatch("last", 64'(res.last), 64'(want.last));
				end
			end
			outstanding <= outcome_q.size();
			fail_count  <= error_tally;
		end
	end

endmodule

// ===== verif/event_queue_subscriber_router_unit_tb.sv =====
// testbench top for the event queue subscriber router: clock, reset, request stimulus, verdict
`timescale 1ns / 1ps
module event_queue_subscriber_router_unit_tb;
	import eqsr_pkg::*;

	localparam int unsigned DEPTH  = 16;
	localparam int unsigned EVENTS = 32;
	localparam int unsigned SLOTS  = 4;
	localparam int          N_RAND = 480;
	localparam int          LIMIT  = 200000;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      start;
	logic      busy;
	eqsr_req_t req;
	logic      res_strobe;
	eqsr_res_t res;
	int        fail_count;
	int        outstanding;
	int        cycles = 0;
	int        idle_pct = 0;

	always #1 clk = ~clk;

	event_queue_subscriber_router_unit #(
		.QUEUE_DEPTH(DEPTH), .EVENT_COUNT(EVENTS), .SLOTS_PER_EVENT(SLOTS)
	) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .res_strobe(res_strobe), .res(res)
	);

	eqsr_router_checker #(
		.QUEUE_DEPTH(DEPTH), .EVENT_COUNT(EVENTS), .SLOTS_PER_EVENT(SLOTS)
	) u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.res_strobe(res_strobe), .res(res), .fail_count(fail_count),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic eqsr_req_t mk_req(input logic [2:0] op, input logic [7:0] ev,
		input logic [7:0] hd, input logic [31:0] pl);
		eqsr_req_t r;
		r.operation  = op;
		r.event_id   = ev;
		r.handler_id = hd;
		r.payload    = pl;
		return r;
	endfunction

	function automatic logic [7:0] rand_event();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			return ($urandom_range(0, 4) == 4) ? 8'(EVENTS - 1) : 8'($urandom_range(0, 3));
		else if (pick < 90)
			return 8'($urandom_range(0, EVENTS - 1));
		else
			return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] rand_handler();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 75)
			return 8'($urandom_range(1, 6));
		else if (pick < 85)
			return 8'd0;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	task automatic issue(input eqsr_req_t r);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < idle_pct)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) begin
				req <= mk_req(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), $urandom);
				@(posedge clk);
			end
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		int         pick;
		logic [2:0] op;
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(mk_req(OP_DISPATCH, 8'd0, 8'd0, 32'd0));
		issue(mk_req(OP_SUBSCRIBE, 8'd0, 8'd0, 32'd0));
		issue(mk_req(OP_SUBSCRIBE, 8'(EVENTS), 8'd1, 32'd0));
		issue(mk_req(OP_SUBSCRIBE, 8'hff, 8'hff, 32'hffffffff));
		issue(mk_req(OP_SUBSCRIBE, 8'(EVENTS - 1), 8'hff, 32'd0));
		issue(mk_req(OP_SUBSCRIBE, 8'(EVENTS - 1), 8'hff, 32'd0));
		issue(mk_req(OP_SUBSCRIBE, 8'(EVENTS - 1), 8'd1, 32'd0));
		issue(mk_req(OP_SUBSCRIBE, 8'(EVENTS - 1), 8'd2, 32'd0));
		issue(mk_req(OP_SUBSCRIBE, 8'(EVENTS - 1), 8'd3, 32'd0));
		issue(mk_req(OP_SUBSCRIBE, 8'(EVENTS - 1), 8'd4, 32'd0));
		issue(mk_req(OP_UNSUBSCRIBE, 8'(EVENTS - 1), 8'd2, 32'd0));
		issue(mk_req(OP_UNSUBSCRIBE, 8'(EVENTS - 1), 8'd2, 32'd0));
		issue(mk_req(OP_UNSUBSCRIBE, 8'd40, 8'd1, 32'd0));
		issue(mk_req(OP_UNSUBSCRIBE, 8'd1, 8'd0, 32'd0));
		issue(mk_req(OP_SUBSCRIBE, 8'(EVENTS - 1), 8'd4, 32'd0));
		issue(mk_req(OP_POST, 8'(EVENTS - 1), 8'd0, 32'hffffffff));
		issue(mk_req(OP_POST, 8'hff, 8'hff, 32'd0));
		issue(mk_req(OP_POST, 8'd0, 8'd0, 32'h5a5a_a5a5));
		repeat (3) issue(mk_req(OP_DISPATCH, 8'd0, 8'd0, 32'd0));
		issue(mk_req(3'd5, 8'd1, 8'd1, 32'd1));
		issue(mk_req(3'd7, 8'hff, 8'hff, 32'hffffffff));
		// fill the ring to its limit, then one more
		for (int i = 0; i < DEPTH; i++)
			issue(mk_req(OP_POST, 8'(i * 17), 8'd0, $urandom));
		issue(mk_req(OP_FLUSH, 8'd0, 8'd0, 32'd0));
		issue(mk_req(OP_DISPATCH, 8'd0, 8'd0, 32'd0));

		for (int n = 0; n < N_RAND; n++) begin
			case (n * 4 / N_RAND)
				0: idle_pct = 0;
				1: idle_pct = 52;
				2: idle_pct = 0;
				default: idle_pct = 12;
			endcase
			pick = $urandom_range(0, 99);
			// alternate stretches that grow the queue and stretches that drain it
			if (((n / 40) % 2) == 0) begin
				if (pick < 20)      op = OP_SUBSCRIBE;
				else if (pick < 30) op = OP_UNSUBSCRIBE;
				else if (pick < 80) op = OP_POST;
				else if (pick < 95) op = OP_DISPATCH;
				else if (pick < 97) op = OP_FLUSH;
				else                op = 3'($urandom_range(5, 7));
			end else begin
				if (pick < 20)      op = OP_SUBSCRIBE;
				else if (pick < 30) op = OP_UNSUBSCRIBE;
				else if (pick < 50) op = OP_POST;
				else if (pick < 95) op = OP_DISPATCH;
				else if (pick < 97) op = OP_FLUSH;
				else                op = 3'($urandom_range(5, 7));
			end
			issue(mk_req(op, rand_event(), rand_handler(), $urandom));
		end

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/eqsr_pkg.sv
hdl/eqsr_sub_mem.sv
hdl/eqsr_ring_mem.sv
hdl/eqsr_slot_unit.sv
hdl/event_queue_subscriber_router_unit.sv
verif/eqsr_router_checker.sv
verif/event_queue_subscriber_router_unit_tb.sv
